// File: sv/rpgc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radius point grouping package
// Sizes, codes and entry layout shared by the grouping core, its divider and
// its channel interfaces.
// ----------------------------------------------------------------------------
package rpgc_pkg;

    // Table and field sizes.
    localparam int MAX_CLUSTERS = 64;
    localparam int COORD_BITS   = 12;
    localparam int COUNT_BITS   = 16;
    localparam int IDX_BITS     = $clog2(MAX_CLUSTERS);
    localparam int TOT_BITS     = $clog2(MAX_CLUSTERS + 1);
    localparam int SUM_BITS     = COORD_BITS + COUNT_BITS;
    localparam int CENT_BITS    = COORD_BITS + 8;
    localparam int DIVD_BITS    = SUM_BITS + 8;
    localparam int DCNT_BITS    = $clog2(DIVD_BITS + 1);
    localparam int DIST_BITS    = 2 * COORD_BITS + 1;
    localparam int RADIUS_BITS  = 25;
    localparam int REQ_BITS     = 4;
    localparam int CMP_BITS     = (DIST_BITS > RADIUS_BITS) ? DIST_BITS : RADIUS_BITS;
    localparam int ACT_BITS     = 2;
    localparam int STAT_BITS    = 3;
    localparam int ADDR_BITS    = 3;

    // Register reset values and the minimum-of-four request code and count.
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(16);
    localparam logic [REQ_BITS-1:0]    REQ_RESET    = REQ_BITS'(4);
    localparam logic [REQ_BITS-1:0]    REQ_MIN_FOUR = REQ_BITS'(4);
    localparam logic [COUNT_BITS-1:0]  MIN_FOUR     = COUNT_BITS'(4);

    // Register addresses.
    localparam logic [ADDR_BITS-1:0] ADDR_RADIUS = 3'd0;
    localparam logic [ADDR_BITS-1:0] ADDR_REQ    = 3'd4;

    // Actions. The unused code is ignored by the block.
    localparam logic [ACT_BITS-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_REPORT = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_CLEAR  = 2'd2;
    localparam logic [ACT_BITS-1:0] ACT_UNUSED = 2'd3;

    // Result status codes.
    localparam logic [STAT_BITS-1:0] ST_JOINED  = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_NEW     = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_SAT     = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_CLEARED = 3'd4;
    localparam logic [STAT_BITS-1:0] ST_REPORT  = 3'd5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // One cluster table entry.
    typedef struct packed {
        logic [COORD_BITS-1:0] key_x;
        logic [COORD_BITS-1:0] key_y;
        logic [SUM_BITS-1:0]   sum_x;
        logic [SUM_BITS-1:0]   sum_y;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

endpackage
`default_nettype wire

// File: sv/rpgc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radius point grouping channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface rpgc_cmd_if;
    import rpgc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ACT_BITS-1:0]   action;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    modport source  (output valid, action, point_x, point_y, input ready);
    modport sink    (input valid, action, point_x, point_y, output ready);
    modport monitor (input valid, ready, action, point_x, point_y);
endinterface

interface rpgc_res_if;
    import rpgc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [STAT_BITS-1:0]  status;
    logic [CENT_BITS-1:0]  centroid_x;
    logic [CENT_BITS-1:0]  centroid_y;
    logic [COUNT_BITS-1:0] point_count;
    logic                  corner_valid;
    logic                  last;
    modport source  (output valid, status, centroid_x, centroid_y, point_count,
                     corner_valid, last, input ready);
    modport sink    (input valid, status, centroid_x, centroid_y, point_count,
                     corner_valid, last, output ready);
    modport monitor (input valid, ready, status, centroid_x, centroid_y, point_count,
                     corner_valid, last);
endinterface
`default_nettype wire

// File: sv/rpgc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radius point grouping centroid divider
// Restoring divider giving one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpgc_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [rpgc_pkg::DIVD_BITS-1:0]  i_dividend,
    input  wire logic [rpgc_pkg::COUNT_BITS-1:0] i_divisor,
    output logic                                o_done,
    output logic [rpgc_pkg::CENT_BITS-1:0]       o_quotient
);
    import rpgc_pkg::*;

    logic                  r_busy;
    logic [DCNT_BITS-1:0]  r_cnt;
    logic [DIVD_BITS-1:0]  r_q;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  take;

    // Shift the next dividend bit into the remainder and try a subtraction.
    assign rem_sh = {r_rem, r_q[DIVD_BITS-1]};
    assign take   = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_BITS'(DIVD_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DCNT_BITS'(1);
            if (r_cnt == DCNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIVD_BITS-2:0], take};
            r_rem <= take ? COUNT_BITS'(rem_sh - {1'b0, r_div})
                          : rem_sh[COUNT_BITS-1:0];
        end
    end

    assign o_done     = !r_busy;
    assign o_quotient = r_q[CENT_BITS-1:0];
endmodule
`default_nettype wire

// File: sv/radius_point_grouping_centroid_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radius point grouping centroid core
// Leader clustering of pixel points into a key-ordered table of centroids.
// ----------------------------------------------------------------------------
// The block takes one command item at a time. An add reads the cluster table
// one entry per cycle from a single-port-read memory. When a new cluster is
// inserted ahead of existing keys, the entries at and above the insertion
// slot are moved up one at a time to open it. A report emits one result per
// cluster; two bit-serial dividers form its two centroid coordinates in
// parallel. The table needs no clearing pass after reset.
module radius_point_grouping_centroid_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rpgc_cmd_if.sink                           i_cmd,
    rpgc_res_if.source                         o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rpgc_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import rpgc_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_DECIDE  = 4'd2;
    localparam logic [3:0] S_JOIN    = 4'd3;
    localparam logic [3:0] S_FULL    = 4'd4;
    localparam logic [3:0] S_SHIFT0  = 4'd5;
    localparam logic [3:0] S_SHIFT   = 4'd6;
    localparam logic [3:0] S_INS     = 4'd7;
    localparam logic [3:0] S_CLEAR   = 4'd8;
    localparam logic [3:0] S_RPT_RD  = 4'd9;
    localparam logic [3:0] S_RPT_LD  = 4'd10;
    localparam logic [3:0] S_RPT_DIV = 4'd11;
    localparam logic [3:0] S_RPT_OUT = 4'd12;

    // Configuration registers.
    logic [RADIUS_BITS-1:0] r_radius;
    logic [REQ_BITS-1:0]    r_req;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_REQ) ? 32'(r_req) : 32'(r_radius);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            r_req    <= REQ_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_RADIUS) begin
                r_radius <= pwdata[RADIUS_BITS-1:0];
            end else if (paddr == ADDR_REQ) begin
                r_req <= pwdata[REQ_BITS-1:0];
            end
        end
    end

    // Cluster table memory with registered read data.
    t_entry                mem [MAX_CLUSTERS];
    t_entry                r_rd;
    logic [IDX_BITS-1:0]   rd_addr;
    logic                  we;
    logic [IDX_BITS-1:0]   wa;
    t_entry                wd;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[rd_addr];
    end

    // Control state.
    logic [3:0]            r_state, n_state;
    logic [TOT_BITS-1:0]   r_total, n_total;
    logic [IDX_BITS-1:0]   r_idx, n_idx;
    logic [TOT_BITS-1:0]   r_pos, n_pos;
    logic                  r_eq, n_eq;
    t_entry                r_ent, n_ent;
    logic [IDX_BITS-1:0]   r_hit, n_hit;
    logic [COORD_BITS-1:0] r_x, n_x;
    logic [COORD_BITS-1:0] r_y, n_y;
    logic [COUNT_BITS-1:0] r_n, n_n;

    // Output register.
    logic                  r_ovalid, n_ovalid;
    logic [STAT_BITS-1:0]  r_status, n_status;
    logic [CENT_BITS-1:0]  r_cx, n_cx;
    logic [CENT_BITS-1:0]  r_cy, n_cy;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic                  r_cv, n_cv;
    logic                  r_last, n_last;

    // Dividers for the two centroid coordinates.
    logic                 div_start;
    logic                 done_x, done_y;
    logic [CENT_BITS-1:0] q_x, q_y;

    rpgc_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_rd.sum_x, 8'd0}),
        .i_divisor  (r_rd.count),
        .o_done     (done_x),
        .o_quotient (q_x)
    );

    rpgc_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_rd.sum_y, 8'd0}),
        .i_divisor  (r_rd.count),
        .o_done     (done_y),
        .o_quotient (q_y)
    );

    // Distance and ordering tests against the entry just read.
    logic [COORD_BITS-1:0]   dx, dy;
    logic [2*COORD_BITS-1:0] dxq, dyq;
    logic [DIST_BITS-1:0]    dsq;
    logic                    rhit, eq, less;
    logic                    out_free;
    logic                    accept;
    logic [IDX_BITS-1:0]     last_idx;

    assign dx   = (r_x > r_rd.key_x) ? r_x - r_rd.key_x : r_rd.key_x - r_x;
    assign dy   = (r_y > r_rd.key_y) ? r_y - r_rd.key_y : r_rd.key_y - r_y;
    assign dxq  = dx * dx;
    assign dyq  = dy * dy;
    assign dsq  = DIST_BITS'(dxq) + DIST_BITS'(dyq);
    assign rhit = CMP_BITS'(dsq) < CMP_BITS'(r_radius);
    assign eq   = (r_rd.key_x == r_x) && (r_rd.key_y == r_y);
    assign less = (r_rd.key_x < r_x) || ((r_rd.key_x == r_x) && (r_rd.key_y < r_y));

    assign out_free = !r_ovalid || o_res.ready;
    assign accept   = i_cmd.valid && i_cmd.ready;
    assign last_idx = IDX_BITS'(r_total - TOT_BITS'(1));
    assign div_start = (r_state == S_RPT_LD);

    assign i_cmd.ready = (r_state == S_IDLE);

    // Read address for the next cycle.
    always_comb begin
        unique case (r_state)
            S_SCAN:  rd_addr = r_idx + IDX_BITS'(1);
            S_SHIFT: rd_addr = r_idx - IDX_BITS'(1);
            S_IDLE:  rd_addr = '0;
            default: rd_addr = r_idx;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_eq     = r_eq;
        n_ent    = r_ent;
        n_hit    = r_hit;
        n_x      = r_x;
        n_y      = r_y;
        n_n      = r_n;
        n_ovalid = r_ovalid && !o_res.ready;
        n_status = r_status;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_cnt    = r_cnt;
        n_cv     = r_cv;
        n_last   = r_last;
        we       = 1'b0;
        wa       = r_idx;
        wd       = r_rd;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_x   = i_cmd.point_x;
                    n_y   = i_cmd.point_y;
                    n_eq  = 1'b0;
                    n_pos = '0;
                    n_idx = '0;
                    if (i_cmd.action == ACT_ADD) begin
                        n_state = (r_total == '0) ? S_DECIDE : S_SCAN;
                    end else if (i_cmd.action == ACT_REPORT) begin
                        n_state = (r_total == '0) ? S_IDLE : S_RPT_RD;
                    end else if (i_cmd.action == ACT_CLEAR) begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_SCAN: begin
                // A radius hit ends the scan; an exact key is kept as fallback.
                if (rhit) begin
                    n_ent   = r_rd;
                    n_hit   = r_idx;
                    n_state = S_JOIN;
                end else begin
                    if (eq && !r_eq) begin
                        n_eq  = 1'b1;
                        n_ent = r_rd;
                        n_hit = r_idx;
                    end
                    n_pos = r_pos + TOT_BITS'(less);
                    if (r_idx == last_idx) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_idx = r_idx + IDX_BITS'(1);
                    end
                end
            end
            S_DECIDE: begin
                if (r_eq) begin
                    n_state = S_JOIN;
                end else if (r_total == TOT_BITS'(MAX_CLUSTERS)) begin
                    n_state = S_FULL;
                end else if (r_pos == r_total) begin
                    n_state = S_INS;
                end else begin
                    n_idx   = last_idx;
                    n_state = S_SHIFT0;
                end
            end
            S_SHIFT0: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                // Move one entry up to open the insertion slot.
                we = 1'b1;
                wa = r_idx + IDX_BITS'(1);
                wd = r_rd;
                if (r_idx == r_pos[IDX_BITS-1:0]) begin
                    n_state = S_INS;
                end else begin
                    n_idx = r_idx - IDX_BITS'(1);
                end
            end
            S_INS: begin
                if (out_free) begin
                    we          = 1'b1;
                    wa          = r_pos[IDX_BITS-1:0];
                    wd.key_x    = r_x;
                    wd.key_y    = r_y;
                    wd.sum_x    = SUM_BITS'(r_x);
                    wd.sum_y    = SUM_BITS'(r_y);
                    wd.count    = COUNT_BITS'(1);
                    n_total     = r_total + TOT_BITS'(1);
                    n_ovalid    = 1'b1;
                    n_status    = ST_NEW;
                    n_cx        = '0;
                    n_cy        = '0;
                    n_cnt       = COUNT_BITS'(1);
                    n_cv        = 1'b0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_JOIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_cx     = '0;
                    n_cy     = '0;
                    n_cv     = 1'b0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                    if (r_ent.count == COUNT_MAX) begin
                        n_status = ST_SAT;
                        n_cnt    = r_ent.count;
                    end else begin
                        we       = 1'b1;
                        wa       = r_hit;
                        wd       = r_ent;
                        wd.sum_x = r_ent.sum_x + SUM_BITS'(r_x);
                        wd.sum_y = r_ent.sum_y + SUM_BITS'(r_y);
                        wd.count = r_ent.count + COUNT_BITS'(1);
                        n_status = ST_JOINED;
                        n_cnt    = r_ent.count + COUNT_BITS'(1);
                    end
                end
            end
            S_FULL: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_status = ST_FULL;
                    n_cx     = '0;
                    n_cy     = '0;
                    n_cnt    = '0;
                    n_cv     = 1'b0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (out_free) begin
                    n_total  = '0;
                    n_ovalid = 1'b1;
                    n_status = ST_CLEARED;
                    n_cx     = '0;
                    n_cy     = '0;
                    n_cnt    = '0;
                    n_cv     = 1'b0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_RPT_RD: begin
                n_state = S_RPT_LD;
            end
            S_RPT_LD: begin
                n_n     = r_rd.count;
                n_state = S_RPT_DIV;
            end
            S_RPT_DIV: begin
                if (done_x && done_y) begin
                    n_state = S_RPT_OUT;
                end
            end
            S_RPT_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_status = ST_REPORT;
                    n_cx     = (r_n != '0) ? q_x : '0;
                    n_cy     = (r_n != '0) ? q_y : '0;
                    n_cnt    = r_n;
                    n_cv     = (r_n != '0) && !r_n[0] &&
                               !((r_req == REQ_MIN_FOUR) && (r_n < MIN_FOUR));
                    n_last   = (r_idx == last_idx);
                    if (r_idx == last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_BITS'(1);
                        n_state = S_RPT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_total  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_eq     <= n_eq;
        r_ent    <= n_ent;
        r_hit    <= n_hit;
        r_x      <= n_x;
        r_y      <= n_y;
        r_n      <= n_n;
        r_status <= n_status;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_cnt    <= n_cnt;
        r_cv     <= n_cv;
        r_last   <= n_last;
    end

    // Result channel.
    assign o_res.valid        = r_ovalid;
    assign o_res.status       = r_status;
    assign o_res.centroid_x   = r_cx;
    assign o_res.centroid_y   = r_cy;
    assign o_res.point_count  = r_cnt;
    assign o_res.corner_valid = r_cv;
    assign o_res.last         = r_last;
endmodule
`default_nettype wire

// File: sim/rpgc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radius point grouping result checker
// Watches the command and result channels, keeps its own copy of the cluster
// table and compares every result item with the oldest predicted one.
// ----------------------------------------------------------------------------
module rpgc_result_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    rpgc_cmd_if.monitor                           i_cmd_mon,
    rpgc_res_if.monitor                           i_res_mon,
    input  wire logic [rpgc_pkg::RADIUS_BITS-1:0] i_radius_sq,
    input  wire logic [rpgc_pkg::REQ_BITS-1:0]    i_req_count,
    output int                                    o_errors,
    output int                                    o_pending
);
    import rpgc_pkg::*;

    typedef struct packed {
        logic [STAT_BITS-1:0]  status;
        logic [CENT_BITS-1:0]  cx;
        logic [CENT_BITS-1:0]  cy;
        logic [COUNT_BITS-1:0] cnt;
        logic                  cvalid;
        logic                  last;
    } t_result;

    t_result expected_results[$];
    t_entry  clusters[MAX_CLUSTERS];
    int      cluster_num;

    function automatic t_result make_result(logic [STAT_BITS-1:0] st,
                                            logic [CENT_BITS-1:0] cx,
                                            logic [CENT_BITS-1:0] cy,
                                            logic [COUNT_BITS-1:0] cnt,
                                            logic v, logic l);
        t_result r;
        r.status = st; r.cx = cx; r.cy = cy; r.cnt = cnt; r.cvalid = v; r.last = l;
        return r;
    endfunction

    // Append one predicted result item at the tail of the queue.
    function automatic void queue_result(t_result r);
        expected_results = {expected_results, r};
    endfunction

    // Predict the results of one accepted command item.
    task automatic predict_grouping(logic [ACT_BITS-1:0] act,
                                    logic [COORD_BITS-1:0] px,
                                    logic [COORD_BITS-1:0] py);
        int hit;
        int pos;
        longint dx;
        longint dy;
        longint n;
        logic ok;
        logic [CENT_BITS-1:0] mx;
        logic [CENT_BITS-1:0] my;
        hit = -1;
        if (act == ACT_ADD) begin
            for (int i = 0; i < cluster_num && hit < 0; i++) begin
                dx = longint'(px) - longint'(clusters[i].key_x);
                dy = longint'(py) - longint'(clusters[i].key_y);
                if (dx * dx + dy * dy < longint'(i_radius_sq)) hit = i;
            end
            // A point equal to a key joins it even with a zero radius.
            for (int i = 0; i < cluster_num && hit < 0; i++)
                if (clusters[i].key_x == px && clusters[i].key_y == py) hit = i;
            if (hit >= 0) begin
                if (clusters[hit].count == COUNT_MAX) begin
                    queue_result(make_result(ST_SAT, 0, 0, clusters[hit].count, 0, 1));
                end else begin
                    clusters[hit].sum_x += px;
                    clusters[hit].sum_y += py;
                    clusters[hit].count += 1;
                    queue_result(make_result(ST_JOINED, 0, 0, clusters[hit].count, 0, 1));
                end
            end else if (cluster_num >= MAX_CLUSTERS) begin
                queue_result(make_result(ST_FULL, 0, 0, 0, 0, 1));
            end else begin
                pos = 0;
                while (pos < cluster_num && (clusters[pos].key_x < px ||
                       (clusters[pos].key_x == px && clusters[pos].key_y < py)))
                    pos++;
                for (int i = cluster_num; i > pos; i--) clusters[i] = clusters[i-1];
                clusters[pos].key_x = px;
                clusters[pos].key_y = py;
                clusters[pos].sum_x = px;
                clusters[pos].sum_y = py;
                clusters[pos].count = 1;
                cluster_num++;
                queue_result(make_result(ST_NEW, 0, 0, 1, 0, 1));
            end
        end else if (act == ACT_REPORT) begin
            for (int i = 0; i < cluster_num; i++) begin
                n = clusters[i].count;
                ok = (n != 0) && (n % 2 == 0) && !(i_req_count == REQ_MIN_FOUR && n < 4);
                mx = '0;
                my = '0;
                // An empty cluster reports a zero centroid.
                if (n != 0) begin
                    mx = CENT_BITS'((longint'(clusters[i].sum_x) << 8) / n);
                    my = CENT_BITS'((longint'(clusters[i].sum_y) << 8) / n);
                end
                queue_result(make_result(ST_REPORT, mx, my,
                    clusters[i].count, ok, i == cluster_num - 1));
            end
        end else if (act == ACT_CLEAR) begin
            cluster_num = 0;
            queue_result(make_result(ST_CLEARED, 0, 0, 0, 0, 1));
        end
    endtask

    // Prediction on accepted commands and comparison on accepted results.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cluster_num = 0;
            o_errors    <= 0;
        end else begin
            if (i_cmd_mon.valid && i_cmd_mon.ready)
                predict_grouping(i_cmd_mon.action, i_cmd_mon.point_x, i_cmd_mon.point_y);
            if (i_res_mon.valid && i_res_mon.ready) begin
                got = make_result(i_res_mon.status, i_res_mon.centroid_x,
                                  i_res_mon.centroid_y, i_res_mon.point_count,
                                  i_res_mon.corner_valid, i_res_mon.last);
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected st=%0d cx=%h cy=%h n=%0d v=%b l=%b",
                                 $time, want.status, want.cx, want.cy, want.cnt,
                                 want.cvalid, want.last);
                        $display("%0t:          actual   st=%0d cx=%h cy=%h n=%0d v=%b l=%b",
                                 $time, got.status, got.cx, got.cy, got.cnt,
                                 got.cvalid, got.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: sim/tb_radius_point_grouping_centroid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radius point grouping centroid core testbench
// Drives directed and random add, report, clear and unused items with random idling,
// rewrites both registers between phases and leaves checking to the checker.
// ----------------------------------------------------------------------------
module tb_radius_point_grouping_centroid_core;
    import rpgc_pkg::*;

    localparam longint CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic [RADIUS_BITS-1:0] radius_sq;
    logic [REQ_BITS-1:0]    req_count;
    logic quiet;
    int   errors, pending;
    longint cycles;

    rpgc_cmd_if cmd_ch();
    rpgc_res_if res_ch();

    radius_point_grouping_centroid_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd_ch.sink), .o_res(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    rpgc_result_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_mon(cmd_ch.monitor),
        .i_res_mon(res_ch.monitor), .i_radius_sq(radius_sq), .i_req_count(req_count),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side stalls in short random bursts.
    always @(negedge i_clk) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
            res_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge i_clk);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [ADDR_BITS-1:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_RADIUS) radius_sq <= data[RADIUS_BITS-1:0];
        else req_count <= data[REQ_BITS-1:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Valid stays high after acceptance until the next item or an idle gap.
    task automatic send_item(logic [ACT_BITS-1:0] act, logic [COORD_BITS-1:0] px,
                             logic [COORD_BITS-1:0] py);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.action  <= act;
        cmd_ch.point_x <= px;
        cmd_ch.point_y <= py;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait until all results are in, plus the worst add latency.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // Mostly adds clustered near a few centres; also noise, report, clear, unused.
    task automatic random_phase(int items, int spread);
        int r;
        logic [COORD_BITS-1:0] cx, cy;
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(0, 99);
            cx = COORD_BITS'($urandom_range(0, 7) * 512 + 100);
            cy = COORD_BITS'($urandom_range(0, 7) * 512 + 100);
            if (r < 70)
                send_item(ACT_ADD, cx + COORD_BITS'($urandom_range(0, spread)),
                          cy + COORD_BITS'($urandom_range(0, spread)));
            else if (r < 82)
                send_item(ACT_ADD, COORD_BITS'($urandom), COORD_BITS'($urandom));
            else if (r < 93)
                send_item(ACT_REPORT, COORD_BITS'($urandom), COORD_BITS'($urandom));
            else if (r < 97)
                send_item(ACT_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom));
            else
                send_item(ACT_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom));
        end
        send_item(ACT_REPORT, 0, 0);
    endtask

    initial begin
        cycles = 0;
        quiet = 1'b0;
        radius_sq = RADIUS_RESET;
        req_count = REQ_RESET;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cmd_ch.valid = 1'b0; cmd_ch.action = ACT_ADD;
        cmd_ch.point_x = '0; cmd_ch.point_y = '0;
        res_ch.ready = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty report, extremes, exact key with zero radius, unused action.
        send_item(ACT_REPORT, 0, 0);
        send_item(ACT_ADD, 0, 0);
        send_item(ACT_ADD, 12'hFFF, 12'hFFF);
        send_item(ACT_ADD, 1, 1);
        send_item(ACT_ADD, 12'hFFF, 12'hFFE);
        send_item(ACT_ADD, 12'h800, 12'h7FF);
        send_item(ACT_UNUSED, 12'h123, 12'h456);
        send_item(ACT_REPORT, 0, 0);
        drain();
        write_reg(ADDR_RADIUS, 32'd0);
        write_reg(ADDR_REQ, 32'd0);
        send_item(ACT_ADD, 0, 0);
        send_item(ACT_ADD, 12'h800, 12'h7FF);
        send_item(ACT_ADD, 12'h801, 12'h7FF);
        send_item(ACT_REPORT, 0, 0);
        send_item(ACT_CLEAR, 0, 0);
        drain();

        // Table full: 64 distinct keys and one more.
        for (int k = 0; k < MAX_CLUSTERS + 1; k++)
            send_item(ACT_ADD, COORD_BITS'(4095 - k * 60), COORD_BITS'(k * 61));
        send_item(ACT_REPORT, 0, 0);
        send_item(ACT_CLEAR, 0, 0);
        drain();

        // Largest radius: everything joins the first cluster.
        write_reg(ADDR_RADIUS, 32'h1FF_FFFF);
        write_reg(ADDR_REQ, 32'd15);
        random_phase(30, 4095);
        send_item(ACT_CLEAR, 0, 0);
        drain();

        write_reg(ADDR_RADIUS, 32'd400);
        write_reg(ADDR_REQ, 32'd4);
        random_phase(50, 30);
        drain();

        write_reg(ADDR_RADIUS, 32'd16);
        write_reg(ADDR_REQ, 32'd2);
        quiet = 1'b1;
        random_phase(40, 6);
        drain();

        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
sv/rpgc_pkg.sv
sv/rpgc_if.sv
sv/rpgc_div.sv
sv/radius_point_grouping_centroid_core.sv
sim/rpgc_result_checker.sv
sim/tb_radius_point_grouping_centroid_core.sv
